// ----- rtl/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// K-way merge package
// Shared widths, entry and result types, and the key ordering used by the
// heap sequencer and the channel interfaces.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int VAL_W  = 32;
  localparam int LIST_W = 5;
  localparam int SRC_W  = 4;
  localparam int CFG_W  = 5;
  localparam int ENTRY_W = VAL_W + LIST_W;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [LIST_W-1:0]       list_t;

  typedef struct packed {
    value_t value;
    list_t  list;
  } entry_t;

  typedef struct packed {
    value_t             merged_value;
    logic [SRC_W-1:0]   source_list;
    logic               value_valid;
    logic               merge_done;
  } result_t;

  localparam result_t DONE_RESULT = '{
    merged_value: '0,
    source_list:  '0,
    value_valid:  1'b0,
    merge_done:   1'b1
  };

  // Order by signed value, then by list number on equal values.
  function automatic logic entry_lt(entry_t a, entry_t b);
    logic [ENTRY_W-1:0] ka;
    logic [ENTRY_W-1:0] kb;
    ka = {~a.value[VAL_W-1], a.value[VAL_W-2:0], a.list};
    kb = {~b.value[VAL_W-1], b.value[VAL_W-2:0], b.list};
    return ka < kb;
  endfunction

  function automatic result_t elem_result(entry_t e);
    result_t r;
    r.merged_value = e.value;
    r.source_list  = e.list[SRC_W-1:0];
    r.value_valid  = 1'b1;
    r.merge_done   = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/kwm_elem_if.sv -----
// ----------------------------------------------------------------------------
// Element channel
// Carries one list element, or the empty mark, per beat.
// ----------------------------------------------------------------------------
interface kwm_elem_if;
  import kwm_pkg::*;

  logic   valid;
  logic   ready;
  value_t element_value;
  logic   element_present;

  modport source (output valid, element_value, element_present, input ready);
  modport sink   (input valid, element_value, element_present, output ready);
endinterface

// ----- rtl/kwm_res_if.sv -----
// ----------------------------------------------------------------------------
// Merged result channel
// Carries one merged element or the completion mark per beat.
// ----------------------------------------------------------------------------
interface kwm_res_if;
  import kwm_pkg::*;

  logic             valid;
  logic             ready;
  value_t           merged_value;
  logic [SRC_W-1:0] source_list;
  logic             value_valid;
  logic             merge_done;

  modport source (output valid, merged_value, source_list, value_valid, merge_done,
                  input ready);
  modport sink   (input valid, merged_value, source_list, value_valid, merge_done,
                  output ready);
endinterface

// ----- rtl/kwm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration channel
// Writes the active list count, one beat per write.
// ----------------------------------------------------------------------------
interface kwm_cfg_if;
  import kwm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] active_lists;

  modport source (output valid, active_lists, input ready);
  modport sink   (input valid, active_lists, output ready);
endinterface

// ----- rtl/k_way_merge_min_heap_top.sv -----
// ----------------------------------------------------------------------------
// K-way merge through a min-heap
// Merges up to MAX_LISTS ascending streams into one ascending stream.
//
//   channel  dir  beat content
//   items    in   element_value, element_present (one list head or next)
//   merged   out  merged_value, source_list, value_valid, merge_done
//   cfg      in   active_lists (number of streams in the merge)
//
// An empty fill beat returns straight to idle; one with an element sifts up
// from its new leaf towards the root. A beat that yields a result may sift
// down from the root, each level waiting on the registered heap memory.
// Items are taken only when the sequencer is idle; a result that meets a full
// output register holds the sequencer. Synchronous reset clears the control
// state only.
// ----------------------------------------------------------------------------
module k_way_merge_min_heap_top #(
  parameter int MAX_LISTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  kwm_elem_if.sink   items,
  kwm_res_if.source  merged,
  kwm_cfg_if.sink    cfg
);
  import kwm_pkg::*;

  localparam int IDX_W = $clog2(MAX_LISTS);
  localparam int CNT_W = $clog2(MAX_LISTS + 1);

  logic [CFG_W-1:0] active_lists;
  logic [CFG_W-1:0] eff_lists;

  logic             res_valid;
  result_t          res;
  logic             res_ready;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr0;
  logic [IDX_W-1:0] ram_raddr1;
  entry_t           ram_rdata0;
  entry_t           ram_rdata1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_lists <= ACTIVE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      active_lists <= cfg.active_lists;
    end
  end

  // Zero counts as one list; counts above capacity are capped.
  always_comb begin
    priority if (active_lists == '0) begin
      eff_lists = CFG_W'(1);
    end else if (int'(active_lists) > MAX_LISTS) begin
      eff_lists = CFG_W'(MAX_LISTS);
    end else begin
      eff_lists = active_lists;
    end
  end

  kwm_heap_ram #(
    .DEPTH (MAX_LISTS),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (ram_rdata0),
    .rdata1 (ram_rdata1)
  );

  kwm_ctrl #(
    .MAX_LISTS (MAX_LISTS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .eff_lists  (eff_lists),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr0 (ram_raddr0),
    .ram_raddr1 (ram_raddr1),
    .ram_rdata0 (ram_rdata0),
    .ram_rdata1 (ram_rdata1)
  );

  assign res_ready = !merged.valid || merged.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      merged.valid <= 1'b0;
    end else if (res_ready) begin
      merged.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      merged.merged_value <= res.merged_value;
      merged.source_list  <= res.source_list;
      merged.value_valid  <= res.value_valid;
      merged.merge_done   <= res.merge_done;
    end
  end

endmodule

// ----- rtl/kwm_heap_ram.sv -----
// ----------------------------------------------------------------------------
// Heap entry memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module kwm_heap_ram #(
  parameter int DEPTH = 16,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  kwm_pkg::entry_t   wdata,
  input  logic [IDX_W-1:0]  raddr0,
  input  logic [IDX_W-1:0]  raddr1,
  output kwm_pkg::entry_t   rdata0,
  output kwm_pkg::entry_t   rdata1
);
  import kwm_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- rtl/kwm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Heap sequencer
// Takes element beats, keeps the heap in the entry memory by sift-up and
// sift-down passes, and hands each result to the output stage.
// ----------------------------------------------------------------------------
module kwm_ctrl #(
  parameter int MAX_LISTS = 16,
  parameter int IDX_W     = $clog2(MAX_LISTS),
  parameter int CNT_W     = $clog2(MAX_LISTS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  kwm_elem_if.sink                   items,
  input  logic [kwm_pkg::CFG_W-1:0]  eff_lists,
  output logic                       res_valid,
  output kwm_pkg::result_t           res,
  input  logic                       res_ready,
  output logic                       ram_we,
  output logic [IDX_W-1:0]           ram_waddr,
  output kwm_pkg::entry_t            ram_wdata,
  output logic [IDX_W-1:0]           ram_raddr0,
  output logic [IDX_W-1:0]           ram_raddr1,
  input  kwm_pkg::entry_t            ram_rdata0,
  input  kwm_pkg::entry_t            ram_rdata1
);
  import kwm_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_UP       = 3'd1;
  localparam logic [2:0] S_UP_CMP   = 3'd2;
  localparam logic [2:0] S_TOP      = 3'd3;
  localparam logic [2:0] S_DOWN     = 3'd4;
  localparam logic [2:0] S_DOWN_CMP = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0]       state;
  logic [CNT_W-1:0] heap_size;
  logic [CFG_W-1:0] fill_count;
  logic             merging;
  list_t            pending_list;

  entry_t           key;
  logic             present;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] n;
  entry_t           carry;

  logic             accept;
  entry_t           in_key;
  logic [CFG_W:0]   fill_next;
  logic             fill_last;
  logic             emit;
  logic [CNT_W-1:0] parent;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W:0]   cw;
  logic [CNT_W:0]   c1;
  logic             down_leaf;
  logic             pick1;
  entry_t           child_e;
  logic [CNT_W:0]   child_i;
  logic             key_wins;
  entry_t           top_e;
  logic             top_to_fin;
  logic             up_move;
  logic             down_move;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign res_valid   = (state == S_FIN);

  always_comb begin
    in_key.value = items.element_value;
    in_key.list  = merging ? pending_list : fill_count;
    fill_next    = {1'b0, fill_count} + (CFG_W+1)'(1);
    fill_last    = fill_next >= {1'b0, eff_lists};
    emit         = merging || fill_last;

    parent   = (idx - CNT_W'(1)) >> 1;
    last_idx = heap_size - CNT_W'(1);
    cw       = {idx, 1'b1};
    c1       = cw + (CNT_W+1)'(1);
    down_leaf = cw >= {1'b0, n};
    pick1    = (c1 < {1'b0, n}) && entry_lt(ram_rdata1, ram_rdata0);
    child_e  = pick1 ? ram_rdata1 : ram_rdata0;
    child_i  = pick1 ? c1 : cw;

    // A new element smaller than the root leaves the heap as it is.
    key_wins   = present && entry_lt(key, ram_rdata0);
    top_e      = key_wins ? key : ram_rdata0;
    top_to_fin = key_wins || (!present && heap_size == CNT_W'(1));

    up_move   = entry_lt(key, ram_rdata0);
    down_move = entry_lt(child_e, carry);
  end

  // Read data is registered, so each address is presented in the state before the one that uses it.
  always_comb begin
    ram_raddr0 = '0;
    ram_raddr1 = last_idx[IDX_W-1:0];
    ram_we     = 1'b0;
    ram_waddr  = idx[IDX_W-1:0];
    ram_wdata  = carry;
    unique case (state)
      S_UP: begin
        ram_raddr0 = parent[IDX_W-1:0];
        if (idx == '0) begin
          ram_we    = 1'b1;
          ram_wdata = key;
        end
      end
      S_UP_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = up_move ? ram_rdata0 : key;
      end
      S_DOWN: begin
        ram_raddr0 = cw[IDX_W-1:0];
        ram_raddr1 = c1[IDX_W-1:0];
        ram_we     = down_leaf;
      end
      S_DOWN_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = down_move ? child_e : carry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      heap_size    <= '0;
      fill_count   <= '0;
      merging      <= 1'b0;
      pending_list <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!emit) begin
              fill_count <= fill_next[CFG_W-1:0];
              if (items.element_present) begin
                heap_size <= heap_size + CNT_W'(1);
                state     <= S_UP;
              end
            end else if (heap_size == '0 && !items.element_present) begin
              merging      <= 1'b0;
              fill_count   <= '0;
              pending_list <= '0;
              state        <= S_FIN;
            end else begin
              if (!merging) begin
                fill_count <= fill_next[CFG_W-1:0];
              end
              if (heap_size == '0) begin
                merging      <= 1'b1;
                pending_list <= in_key.list;
                state        <= S_FIN;
              end else begin
                state <= S_TOP;
              end
            end
          end
        end
        S_UP: begin
          state <= (idx == '0) ? S_IDLE : S_UP_CMP;
        end
        S_UP_CMP: begin
          state <= up_move ? S_UP : S_IDLE;
        end
        S_TOP: begin
          merging      <= 1'b1;
          pending_list <= top_e.list;
          if (!present) begin
            heap_size <= heap_size - CNT_W'(1);
          end
          state <= top_to_fin ? S_FIN : S_DOWN;
        end
        S_DOWN: begin
          state <= down_leaf ? S_FIN : S_DOWN_CMP;
        end
        S_DOWN_CMP: begin
          state <= down_move ? S_DOWN : S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key     <= in_key;
          present <= items.element_present;
          idx     <= heap_size;
          res     <= items.element_present ? elem_result(in_key) : DONE_RESULT;
        end
      end
      S_UP_CMP: begin
        if (up_move) begin
          idx <= parent;
        end
      end
      S_TOP: begin
        res   <= elem_result(top_e);
        carry <= present ? key : ram_rdata1;
        idx   <= '0;
        n     <= present ? heap_size : last_idx;
      end
      S_DOWN_CMP: begin
        if (down_move) begin
          idx <= child_i[CNT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    int'(heap_size) <= MAX_LISTS)
    else $error("heap size above capacity");

  a_size_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(heap_size)) |->
      ($past(state) == S_IDLE || $past(state) == S_TOP))
    else $error("heap size changed outside an accept or a pop");

  a_down_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOWN) |-> (idx < n))
    else $error("sift-down position beyond heap");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res.merge_done) |-> (heap_size == '0 && !merging))
    else $error("completion reported with entries held");
`endif

endmodule
